/* rtl/gbd_pkg.sv */
`default_nettype none
package gbd_pkg;

    localparam int MAX_V = 64;
    localparam int AW    = $clog2(MAX_V);
    localparam int VW    = 7;
    localparam int TW    = 8;
    localparam int DW    = 7;
    localparam int ACW   = 16;

    localparam logic [2:0] CMD_ADD_ARC  = 3'd0;
    localparam logic [2:0] CMD_ADD_EDGE = 3'd1;
    localparam logic [2:0] CMD_CLEAR    = 3'd2;
    localparam logic [2:0] CMD_LOAD     = 3'd3;
    localparam logic [2:0] CMD_BFS      = 3'd4;
    localparam logic [2:0] CMD_DFS      = 3'd5;
    localparam logic [2:0] CMD_PATH     = 3'd6;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_RANGE  = 2'd1;
    localparam logic [1:0] ST_ORDER  = 2'd2;
    localparam logic [1:0] ST_NO_SRC = 2'd3;

    localparam logic [DW-1:0] DIST_INF   = '1;
    localparam logic [TW-1:0] TIME_UNDEF = '1;

    // read and write side of the per-vertex record store
    typedef struct packed {
        logic             rd_en;
        logic [AW-1:0]    rd_addr;
        logic             par_we;
        logic             dist_we;
        logic             disc_we;
        logic             fin_we;
        logic [AW-1:0]    wr_addr;
        logic [VW-1:0]    par_data;
        logic [DW-1:0]    dist_data;
        logic [TW-1:0]    time_data;
        logic [MAX_V-1:0] par_inv;
        logic [MAX_V-1:0] dist_inv;
        logic [MAX_V-1:0] time_inv;
    } vs_cmd_t;

    typedef struct packed {
        logic [VW-1:0] par;
        logic [DW-1:0] hops;
        logic [TW-1:0] disc;
        logic [TW-1:0] fin;
    } vs_rec_t;

    function automatic logic [AW-1:0] first_set(input logic [MAX_V-1:0] x);
        logic [AW-1:0] idx;
        idx = '0;
        for (int i = MAX_V - 1; i >= 0; i--) begin
            if (x[i]) begin
                idx = AW'(i);
            end
        end
        return idx;
    endfunction

    function automatic logic [MAX_V-1:0] bit_of(input logic [AW-1:0] a);
        return {{(MAX_V-1){1'b0}}, 1'b1} << a;
    endfunction

    function automatic logic [MAX_V-1:0] low_mask(input logic [VW-1:0] n);
        logic [MAX_V-1:0] m;
        for (int i = 0; i < MAX_V; i++) begin
            m[i] = (VW'(i) < n);
        end
        return m;
    endfunction

    function automatic logic in_range(input logic [VW-1:0] v, input logic [VW-1:0] n);
        return (v != '0) && (v <= n);
    endfunction

    function automatic logic [AW-1:0] vaddr(input logic [VW-1:0] v);
        logic [VW-1:0] t;
        t = v - VW'(1);
        return t[AW-1:0];
    endfunction

endpackage
`default_nettype wire

/* rtl/gbd_adj_store.sv */
`default_nettype none
module gbd_adj_store
    import gbd_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic [MAX_V-1:0]      row_q,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [MAX_V-1:0] wr_data,
    input  wire logic             clr,
    output logic [MAX_V-1:0]      row_nz
);

    logic [MAX_V-1:0] mem [MAX_V];
    logic [MAX_V-1:0] data_reg;
    logic             hit_reg;
    logic [MAX_V-1:0] valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            data_reg <= mem[rd_addr];
            hit_reg  <= valid_reg[rd_addr];
        end
    end

    // a row never written since clear reads as empty
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (clr) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg <= valid_reg | bit_of(wr_addr);
        end
    end

    assign row_q  = hit_reg ? data_reg : '0;
    assign row_nz = valid_reg;

endmodule
`default_nettype wire

/* rtl/gbd_vertex_store.sv */
`default_nettype none
module gbd_vertex_store
    import gbd_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire vs_cmd_t cmd,
    output vs_rec_t      rec
);

    logic [VW-1:0] par_mem  [MAX_V];
    logic [DW-1:0] dist_mem [MAX_V];
    logic [TW-1:0] disc_mem [MAX_V];
    logic [TW-1:0] fin_mem  [MAX_V];

    logic [MAX_V-1:0] par_ok_reg;
    logic [MAX_V-1:0] dist_ok_reg;
    logic [MAX_V-1:0] disc_ok_reg;
    logic [MAX_V-1:0] fin_ok_reg;

    vs_rec_t       q_reg;
    logic [3:0]    hit_reg;
    logic [MAX_V-1:0] wbit;

    assign wbit = bit_of(cmd.wr_addr);

    always_ff @(posedge aclk) begin
        if (cmd.par_we) begin
            par_mem[cmd.wr_addr] <= cmd.par_data;
        end
        if (cmd.dist_we) begin
            dist_mem[cmd.wr_addr] <= cmd.dist_data;
        end
        if (cmd.disc_we) begin
            disc_mem[cmd.wr_addr] <= cmd.time_data;
        end
        if (cmd.fin_we) begin
            fin_mem[cmd.wr_addr] <= cmd.time_data;
        end
        if (cmd.rd_en) begin
            q_reg   <= {par_mem[cmd.rd_addr], dist_mem[cmd.rd_addr],
                        disc_mem[cmd.rd_addr], fin_mem[cmd.rd_addr]};
            hit_reg <= {par_ok_reg[cmd.rd_addr], dist_ok_reg[cmd.rd_addr],
                        disc_ok_reg[cmd.rd_addr], fin_ok_reg[cmd.rd_addr]};
        end
    end

    // write wins over a bulk invalidate in the same cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            par_ok_reg  <= '0;
            dist_ok_reg <= '0;
            disc_ok_reg <= '0;
            fin_ok_reg  <= '0;
        end else begin
            par_ok_reg  <= (par_ok_reg & ~cmd.par_inv) | (cmd.par_we ? wbit : '0);
            dist_ok_reg <= (dist_ok_reg & ~cmd.dist_inv) | (cmd.dist_we ? wbit : '0);
            disc_ok_reg <= (disc_ok_reg & ~cmd.time_inv) | (cmd.disc_we ? wbit : '0);
            fin_ok_reg  <= (fin_ok_reg & ~cmd.time_inv) | (cmd.fin_we ? wbit : '0);
        end
    end

    assign rec.par  = hit_reg[3] ? q_reg.par  : '0;
    assign rec.hops = hit_reg[2] ? q_reg.hops : DIST_INF;
    assign rec.disc = hit_reg[1] ? q_reg.disc : TIME_UNDEF;
    assign rec.fin  = hit_reg[0] ? q_reg.fin  : TIME_UNDEF;

endmodule
`default_nettype wire

/* rtl/graph_bfs_dfs_engine.sv */
`default_nettype none
// channel | dir | tdata (lsb up)                                   | tuser   | tlast
// s_      | in  | vertex_a[6:0] vertex_b[13:7] pad                 | command | -
// m_      | out | status vertex distance parent discover finish   | -       | last
//         |     | finish_order_vertex path_vertex arc_count pad    |         |
// an arc command reads and rewrites the row of vertex_a, an edge also that of vertex_b;
// clear and order loads act in the idle state; bfs reads the row and record of each
// dequeued vertex, then writes one discovered vertex per scan step; dfs reads order entries,
// a row per discovery and the stack per finish; a path walks a parent per hop; the single
// read port of the adjacency and record memories serializes these steps and result beats
// reset clears all valid bits at once, no sweep; a stalled m_ side holds the walk
// at its next result while the last beat sits in the output register
module graph_bfs_dfs_engine
    import gbd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // vertex_a, vertex_b
    input  wire logic [2:0]  s_tuser,   // command
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,   // status, vertex, distance, parent, discover_time,
                                        // finish_time, finish_order_vertex, path_vertex,
                                        // arc_count
    output logic             m_tlast,
    input  wire logic        cfg_wr_en,
    input  wire logic [6:0]  cfg_wr_data
);

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_A_RD1   = 5'd1;
    localparam logic [4:0] S_A_WR1   = 5'd2;
    localparam logic [4:0] S_A_RD2   = 5'd3;
    localparam logic [4:0] S_A_WR2   = 5'd4;
    localparam logic [4:0] S_B_INIT  = 5'd5;
    localparam logic [4:0] S_B_QRD   = 5'd6;
    localparam logic [4:0] S_B_XRD   = 5'd7;
    localparam logic [4:0] S_B_LOAD  = 5'd8;
    localparam logic [4:0] S_B_SCAN  = 5'd9;
    localparam logic [4:0] S_D_INIT  = 5'd10;
    localparam logic [4:0] S_D_ROOT  = 5'd11;
    localparam logic [4:0] S_D_ROOT2 = 5'd12;
    localparam logic [4:0] S_D_ADJ   = 5'd13;
    localparam logic [4:0] S_D_SCAN  = 5'd14;
    localparam logic [4:0] S_D_TOP   = 5'd15;
    localparam logic [4:0] S_D_TOP2  = 5'd16;
    localparam logic [4:0] S_P_STEP  = 5'd17;
    localparam logic [4:0] S_P_PAR   = 5'd18;
    localparam logic [4:0] S_C_RD    = 5'd19;
    localparam logic [4:0] S_OUT_RD  = 5'd20;
    localparam logic [4:0] S_OUT_LD  = 5'd21;

    localparam logic [1:0] K_SINGLE = 2'd0;
    localparam logic [1:0] K_BFS    = 2'd1;
    localparam logic [1:0] K_DFS    = 2'd2;
    localparam logic [1:0] K_PATH   = 2'd3;

    logic [4:0]      state_reg;
    logic [VW-1:0]   vc_reg;
    logic [2:0]      cmd_reg;
    logic [VW-1:0]   a_reg;
    logic [VW-1:0]   b_reg;
    logic [VW-1:0]   fill_reg;
    logic [VW-1:0]   src_reg;
    logic [ACW-1:0]  arc_reg;
    logic [MAX_V-1:0] white_reg;
    logic [MAX_V-1:0] cand_reg;
    logic [VW-1:0]   head_reg;
    logic [VW-1:0]   tail_reg;
    logic [VW-1:0]   x_reg;
    logic [DW-1:0]   dx_reg;
    logic [TW-1:0]   clock_reg;
    logic [VW-1:0]   r_reg;
    logic [VW-1:0]   done_reg;
    logic [VW-1:0]   top_reg;
    logic [VW-1:0]   v_reg;
    logic [VW-1:0]   cur_reg;
    logic [VW-1:0]   len_reg;
    logic [1:0]      kind_reg;
    logic [1:0]      res_st_reg;
    logic [VW-1:0]   res_v_reg;
    logic [VW-1:0]   idx_reg;
    logic            m_valid_reg;
    logic [71:0]     m_data_reg;
    logic            m_last_reg;

    logic [VW-1:0]    n_eff;
    logic [MAX_V-1:0] vmask;
    logic [2:0]       in_cmd;
    logic [VW-1:0]    in_a;
    logic [VW-1:0]    in_b;
    logic             accept;
    logic             out_free;
    logic             out_load;
    logic [VW-1:0]    fill_base;
    logic [4:0]       idle_state_next;
    logic [1:0]       res_st_next;
    logic [71:0]      m_data_next;

    // memories local to the walker: work queue / stack, visit order, finish list, path chain
    logic [VW-1:0] wk_mem [MAX_V];
    logic [VW-1:0] vo_mem [MAX_V];
    logic [VW-1:0] fl_mem [MAX_V];
    logic [VW-1:0] ch_mem [MAX_V];
    logic [VW-1:0] wk_q_reg;
    logic [VW-1:0] vo_q_reg;
    logic [VW-1:0] fl_q_reg;
    logic [VW-1:0] ch_q_reg;

    logic          wk_we, wk_re, vo_we, vo_re, fl_we, fl_re, ch_we, ch_re;
    logic [AW-1:0] wk_waddr, wk_raddr, vo_waddr, vo_raddr, fl_waddr, fl_raddr;
    logic [AW-1:0] ch_waddr, ch_raddr;
    logic [VW-1:0] wk_wdata, vo_wdata, fl_wdata, ch_wdata;

    logic             adj_rd_en;
    logic [AW-1:0]    adj_rd_addr;
    logic [MAX_V-1:0] adj_row;
    logic             adj_we;
    logic [AW-1:0]    adj_wr_addr;
    logic [MAX_V-1:0] adj_wr_data;
    logic             adj_clr;
    logic [MAX_V-1:0] row_nz;

    vs_cmd_t vs_cmd;
    vs_rec_t vs_rec;

    logic [MAX_V-1:0] b_cand;
    logic [AW-1:0]    b_j;
    logic [MAX_V-1:0] d_cand;
    logic [AW-1:0]    d_j;
    logic             root_ok;
    logic [VW-1:0]    v_sel;
    logic [VW-1:0]    ord_sel;
    logic             res_last;
    logic [VW-1:0]    ch_rd_idx;
    logic [VW-1:0]    dfs_keep;
    logic [VW-1:0]    vo_rd_idx;
    logic [VW-1:0]    fl_rd_idx;

    assign in_cmd   = s_tuser;
    assign in_a     = s_tdata[6:0];
    assign in_b     = s_tdata[13:7];
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign out_load = (state_reg == S_OUT_LD) && out_free;

    assign n_eff = (vc_reg > VW'(MAX_V)) ? VW'(MAX_V) : ((vc_reg == '0) ? VW'(1) : vc_reg);
    assign vmask = low_mask(n_eff);
    assign fill_base = (fill_reg >= n_eff) ? '0 : fill_reg;

    assign b_cand  = cand_reg;
    assign b_j     = first_set(cand_reg);
    assign d_cand  = adj_row & white_reg & vmask;
    assign d_j     = first_set(d_cand);
    assign root_ok = in_range(vo_q_reg, n_eff) && white_reg[vaddr(vo_q_reg)];

    assign dfs_keep  = n_eff - done_reg;
    assign vo_rd_idx = idx_reg + done_reg;
    assign fl_rd_idx = n_eff - VW'(1) - idx_reg;
    assign ch_rd_idx = len_reg - VW'(1) - idx_reg;
    assign ord_sel   = (idx_reg < dfs_keep) ? vo_q_reg : fl_q_reg;

    always_comb begin
        unique case (kind_reg)
            K_SINGLE: v_sel = '0;
            K_PATH:   v_sel = ch_q_reg;
            default:  v_sel = idx_reg + VW'(1);
        endcase
    end

    always_comb begin
        unique case (kind_reg)
            K_SINGLE: res_last = 1'b1;
            K_PATH:   res_last = (idx_reg == len_reg - VW'(1));
            default:  res_last = (idx_reg == n_eff - VW'(1));
        endcase
    end

    // where an accepted command goes and the status it reports
    always_comb begin
        idle_state_next = S_OUT_RD;
        res_st_next     = ST_OK;
        unique case (in_cmd)
            CMD_ADD_ARC, CMD_ADD_EDGE: begin
                if (in_range(in_a, n_eff) && in_range(in_b, n_eff)) begin
                    idle_state_next = S_A_RD1;
                end else begin
                    res_st_next = ST_RANGE;
                end
            end
            CMD_LOAD: begin
                if (!in_range(in_a, n_eff)) begin
                    res_st_next = ST_RANGE;
                end
            end
            CMD_BFS: begin
                if (in_range(in_a, n_eff)) begin
                    idle_state_next = S_B_INIT;
                end else begin
                    res_st_next = ST_RANGE;
                end
            end
            CMD_DFS: begin
                if (fill_reg == n_eff) begin
                    idle_state_next = S_D_INIT;
                end else begin
                    res_st_next = ST_ORDER;
                end
            end
            CMD_PATH: begin
                if (src_reg == '0) begin
                    res_st_next = ST_NO_SRC;
                end else if (!in_range(in_a, n_eff)) begin
                    res_st_next = ST_RANGE;
                end else begin
                    idle_state_next = S_P_STEP;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        m_data_next        = '0;
        m_data_next[1:0]   = res_st_reg;
        m_data_next[8:2]   = res_v_reg;
        m_data_next[70:55] = arc_reg;
        if (res_v_reg != '0) begin
            m_data_next[15:9]  = vs_rec.hops;
            m_data_next[22:16] = vs_rec.par;
            m_data_next[31:23] = (vs_rec.disc == TIME_UNDEF) ? '1 : {1'b0, vs_rec.disc};
            m_data_next[40:32] = (vs_rec.fin == TIME_UNDEF) ? '1 : {1'b0, vs_rec.fin};
        end
        if (kind_reg == K_DFS) begin
            m_data_next[47:41] = ord_sel;
        end
        if (kind_reg == K_PATH) begin
            m_data_next[54:48] = res_v_reg;
        end
    end

    gbd_adj_store u_adj (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (adj_rd_en),
        .rd_addr (adj_rd_addr),
        .row_q   (adj_row),
        .wr_en   (adj_we),
        .wr_addr (adj_wr_addr),
        .wr_data (adj_wr_data),
        .clr     (adj_clr),
        .row_nz  (row_nz)
    );

    gbd_vertex_store u_vs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (vs_cmd),
        .rec     (vs_rec)
    );

    always_ff @(posedge aclk) begin
        if (wk_we) begin
            wk_mem[wk_waddr] <= wk_wdata;
        end
        if (wk_re) begin
            wk_q_reg <= wk_mem[wk_raddr];
        end
        if (vo_we) begin
            vo_mem[vo_waddr] <= vo_wdata;
        end
        if (vo_re) begin
            vo_q_reg <= vo_mem[vo_raddr];
        end
        if (fl_we) begin
            fl_mem[fl_waddr] <= fl_wdata;
        end
        if (fl_re) begin
            fl_q_reg <= fl_mem[fl_raddr];
        end
        if (ch_we) begin
            ch_mem[ch_waddr] <= ch_wdata;
        end
        if (ch_re) begin
            ch_q_reg <= ch_mem[ch_raddr];
        end
    end

    always_comb begin
        adj_rd_en   = 1'b0;
        adj_rd_addr = '0;
        adj_we      = 1'b0;
        adj_wr_addr = '0;
        adj_wr_data = '0;
        adj_clr     = 1'b0;
        vs_cmd      = '0;
        wk_we = 1'b0; wk_waddr = '0; wk_wdata = '0; wk_re = 1'b0; wk_raddr = '0;
        vo_we = 1'b0; vo_waddr = '0; vo_wdata = '0; vo_re = 1'b0; vo_raddr = '0;
        fl_we = 1'b0; fl_waddr = '0; fl_wdata = '0; fl_re = 1'b0; fl_raddr = '0;
        ch_we = 1'b0; ch_waddr = '0; ch_wdata = '0; ch_re = 1'b0; ch_raddr = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (accept && in_cmd == CMD_CLEAR) begin
                    adj_clr         = 1'b1;
                    vs_cmd.par_inv  = row_nz;
                    vs_cmd.dist_inv = row_nz;
                end
                if (accept && in_cmd == CMD_LOAD && in_range(in_a, n_eff)) begin
                    vo_we    = 1'b1;
                    vo_waddr = fill_base[AW-1:0];
                    vo_wdata = in_a;
                end
            end
            S_A_RD1: begin
                adj_rd_en   = 1'b1;
                adj_rd_addr = vaddr(a_reg);
            end
            S_A_WR1: begin
                adj_we      = 1'b1;
                adj_wr_addr = vaddr(a_reg);
                adj_wr_data = adj_row | bit_of(vaddr(b_reg));
            end
            S_A_RD2: begin
                adj_rd_en   = 1'b1;
                adj_rd_addr = vaddr(b_reg);
            end
            S_A_WR2: begin
                adj_we      = 1'b1;
                adj_wr_addr = vaddr(b_reg);
                adj_wr_data = adj_row | bit_of(vaddr(a_reg));
            end
            S_B_INIT: begin
                vs_cmd.par_inv   = vmask;
                vs_cmd.dist_inv  = vmask;
                vs_cmd.dist_we   = 1'b1;
                vs_cmd.wr_addr   = vaddr(a_reg);
                vs_cmd.dist_data = '0;
                wk_we    = 1'b1;
                wk_waddr = '0;
                wk_wdata = a_reg;
            end
            S_B_QRD: begin
                wk_re    = (head_reg != tail_reg);
                wk_raddr = head_reg[AW-1:0];
            end
            S_B_XRD: begin
                adj_rd_en      = 1'b1;
                adj_rd_addr    = vaddr(wk_q_reg);
                vs_cmd.rd_en   = 1'b1;
                vs_cmd.rd_addr = vaddr(wk_q_reg);
            end
            S_B_SCAN: begin
                if (b_cand != '0) begin
                    vs_cmd.par_we    = 1'b1;
                    vs_cmd.dist_we   = 1'b1;
                    vs_cmd.wr_addr   = b_j;
                    vs_cmd.par_data  = x_reg;
                    vs_cmd.dist_data = dx_reg + DW'(1);
                    wk_we    = 1'b1;
                    wk_waddr = tail_reg[AW-1:0];
                    wk_wdata = {1'b0, b_j} + VW'(1);
                end
            end
            S_D_INIT: begin
                vs_cmd.par_inv  = vmask;
                vs_cmd.time_inv = vmask;
            end
            S_D_ROOT: begin
                vo_re    = (r_reg != n_eff);
                vo_raddr = r_reg[AW-1:0];
            end
            S_D_ROOT2: begin
                if (root_ok) begin
                    vs_cmd.disc_we   = 1'b1;
                    vs_cmd.wr_addr   = vaddr(vo_q_reg);
                    vs_cmd.time_data = clock_reg + TW'(1);
                    wk_we    = 1'b1;
                    wk_waddr = '0;
                    wk_wdata = vo_q_reg;
                end
            end
            S_D_ADJ: begin
                adj_rd_en   = 1'b1;
                adj_rd_addr = vaddr(v_reg);
            end
            S_D_SCAN: begin
                vs_cmd.time_data = clock_reg + TW'(1);
                if (d_cand != '0) begin
                    vs_cmd.par_we   = 1'b1;
                    vs_cmd.disc_we  = 1'b1;
                    vs_cmd.wr_addr  = d_j;
                    vs_cmd.par_data = v_reg;
                    wk_we    = 1'b1;
                    wk_waddr = top_reg[AW-1:0];
                    wk_wdata = {1'b0, d_j} + VW'(1);
                end else begin
                    vs_cmd.fin_we  = 1'b1;
                    vs_cmd.wr_addr = vaddr(v_reg);
                    fl_we    = 1'b1;
                    fl_waddr = done_reg[AW-1:0];
                    fl_wdata = v_reg;
                end
            end
            S_D_TOP: begin
                wk_re    = (top_reg != '0);
                wk_raddr = vaddr(top_reg);
            end
            S_P_STEP: begin
                if (len_reg != VW'(MAX_V)) begin
                    ch_we    = 1'b1;
                    ch_waddr = len_reg[AW-1:0];
                    ch_wdata = cur_reg;
                    vs_cmd.rd_en   = (cur_reg != src_reg);
                    vs_cmd.rd_addr = vaddr(cur_reg);
                end
            end
            S_C_RD: begin
                ch_re    = 1'b1;
                ch_raddr = ch_rd_idx[AW-1:0];
            end
            S_OUT_RD: begin
                vs_cmd.rd_en   = 1'b1;
                vs_cmd.rd_addr = vaddr(v_sel);
                if (kind_reg == K_DFS) begin
                    vo_re    = 1'b1;
                    vo_raddr = vo_rd_idx[AW-1:0];
                    fl_re    = 1'b1;
                    fl_raddr = fl_rd_idx[AW-1:0];
                end
            end
            S_OUT_LD: begin
                // the new order list is written in place behind the read pointer
                if (out_free && kind_reg == K_DFS) begin
                    vo_we    = 1'b1;
                    vo_waddr = idx_reg[AW-1:0];
                    vo_wdata = ord_sel;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            vc_reg      <= VW'(MAX_V);
            fill_reg    <= '0;
            src_reg     <= '0;
            arc_reg     <= '0;
            m_valid_reg <= 1'b0;
            kind_reg    <= K_SINGLE;
        end else begin
            if (cfg_wr_en) begin
                vc_reg <= cfg_wr_data;
            end
            if (m_valid_reg && m_tready && !out_load) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        cmd_reg    <= in_cmd;
                        a_reg      <= in_a;
                        b_reg      <= in_b;
                        res_st_reg <= res_st_next;
                        res_v_reg  <= '0;
                        kind_reg   <= K_SINGLE;
                        idx_reg    <= '0;
                        state_reg  <= idle_state_next;
                        if (in_cmd == CMD_CLEAR) begin
                            arc_reg <= '0;
                        end
                        if (in_cmd == CMD_LOAD && in_range(in_a, n_eff)) begin
                            fill_reg <= fill_base + VW'(1);
                        end
                        if (in_cmd == CMD_PATH) begin
                            cur_reg <= in_a;
                            len_reg <= '0;
                        end
                    end
                end
                S_A_RD1: state_reg <= S_A_WR1;
                S_A_WR1: begin
                    if (cmd_reg == CMD_ADD_EDGE) begin
                        state_reg <= S_A_RD2;
                    end else begin
                        if (arc_reg != '1) begin
                            arc_reg <= arc_reg + ACW'(1);
                        end
                        state_reg <= S_OUT_RD;
                    end
                end
                S_A_RD2: state_reg <= S_A_WR2;
                S_A_WR2: begin
                    if (arc_reg != '1) begin
                        arc_reg <= arc_reg + ACW'(1);
                    end
                    state_reg <= S_OUT_RD;
                end
                S_B_INIT: begin
                    white_reg <= vmask & ~bit_of(vaddr(a_reg));
                    src_reg   <= a_reg;
                    head_reg  <= '0;
                    tail_reg  <= VW'(1);
                    state_reg <= S_B_QRD;
                end
                S_B_QRD: begin
                    if (head_reg == tail_reg) begin
                        kind_reg  <= K_BFS;
                        idx_reg   <= '0;
                        state_reg <= S_OUT_RD;
                    end else begin
                        state_reg <= S_B_XRD;
                    end
                end
                S_B_XRD: begin
                    x_reg     <= wk_q_reg;
                    state_reg <= S_B_LOAD;
                end
                S_B_LOAD: begin
                    cand_reg  <= adj_row & white_reg & vmask;
                    dx_reg    <= vs_rec.hops;
                    state_reg <= S_B_SCAN;
                end
                S_B_SCAN: begin
                    if (b_cand != '0) begin
                        cand_reg  <= cand_reg & ~bit_of(b_j);
                        white_reg <= white_reg & ~bit_of(b_j);
                        tail_reg  <= tail_reg + VW'(1);
                    end else begin
                        head_reg  <= head_reg + VW'(1);
                        state_reg <= S_B_QRD;
                    end
                end
                S_D_INIT: begin
                    white_reg <= vmask;
                    clock_reg <= '0;
                    r_reg     <= '0;
                    done_reg  <= '0;
                    state_reg <= S_D_ROOT;
                end
                S_D_ROOT: begin
                    if (r_reg == n_eff) begin
                        kind_reg  <= K_DFS;
                        idx_reg   <= '0;
                        state_reg <= S_OUT_RD;
                    end else begin
                        state_reg <= S_D_ROOT2;
                    end
                end
                S_D_ROOT2: begin
                    r_reg <= r_reg + VW'(1);
                    if (root_ok) begin
                        clock_reg <= clock_reg + TW'(1);
                        white_reg <= white_reg & ~bit_of(vaddr(vo_q_reg));
                        top_reg   <= VW'(1);
                        v_reg     <= vo_q_reg;
                        state_reg <= S_D_ADJ;
                    end else begin
                        state_reg <= S_D_ROOT;
                    end
                end
                S_D_ADJ: state_reg <= S_D_SCAN;
                S_D_SCAN: begin
                    clock_reg <= clock_reg + TW'(1);
                    if (d_cand != '0) begin
                        white_reg <= white_reg & ~bit_of(d_j);
                        top_reg   <= top_reg + VW'(1);
                        v_reg     <= {1'b0, d_j} + VW'(1);
                        state_reg <= S_D_ADJ;
                    end else begin
                        done_reg  <= done_reg + VW'(1);
                        top_reg   <= top_reg - VW'(1);
                        state_reg <= S_D_TOP;
                    end
                end
                S_D_TOP: begin
                    if (top_reg == '0) begin
                        state_reg <= S_D_ROOT;
                    end else begin
                        state_reg <= S_D_TOP2;
                    end
                end
                S_D_TOP2: begin
                    v_reg     <= wk_q_reg;
                    state_reg <= S_D_ADJ;
                end
                S_P_STEP: begin
                    if (len_reg == VW'(MAX_V)) begin
                        kind_reg  <= K_SINGLE;
                        state_reg <= S_OUT_RD;
                    end else begin
                        len_reg <= len_reg + VW'(1);
                        if (cur_reg == src_reg) begin
                            kind_reg  <= K_PATH;
                            idx_reg   <= '0;
                            state_reg <= S_C_RD;
                        end else begin
                            state_reg <= S_P_PAR;
                        end
                    end
                end
                S_P_PAR: begin
                    // chain broken: no valid parent, so no path to the source
                    if (vs_rec.par == '0 || vs_rec.par > VW'(MAX_V)) begin
                        kind_reg  <= K_SINGLE;
                        state_reg <= S_OUT_RD;
                    end else begin
                        cur_reg   <= vs_rec.par;
                        state_reg <= S_P_STEP;
                    end
                end
                S_C_RD: state_reg <= S_OUT_RD;
                S_OUT_RD: begin
                    res_v_reg <= v_sel;
                    state_reg <= S_OUT_LD;
                end
                S_OUT_LD: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_last_reg  <= res_last;
                        m_data_reg  <= m_data_next;
                        if (res_last) begin
                            if (kind_reg == K_DFS) begin
                                fill_reg <= n_eff;
                            end
                            state_reg <= S_IDLE;
                        end else begin
                            idx_reg   <= idx_reg + VW'(1);
                            state_reg <= (kind_reg == K_PATH) ? S_C_RD : S_OUT_RD;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule
`default_nettype wire
